@@ hw/rtl/ctm_pkg.sv @@
`default_nettype none

package ctm_pkg;

	// Datapath widths
	localparam int DATA_W     = 32;
	localparam int MAG_W      = DATA_W - 1;
	localparam int DIM_W      = 17;
	localparam int CS_W       = 16;
	localparam int CFG_DATA_W = 16;

	typedef logic signed [DATA_W-1:0] coord_t;
	typedef logic [DIM_W-1:0]         dim_t;
	typedef logic [CS_W-1:0]          cs_t;

	// Tile shapes
	typedef logic [1:0] shape_t;
	localparam shape_t SHAPE_SQUARE   = 2'd0;
	localparam shape_t SHAPE_TRIANGLE = 2'd1;
	localparam shape_t SHAPE_HEXAGON  = 2'd2;
	localparam shape_t SHAPE_NONE     = 2'd3;

	// Register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CELL_SIZE  = 2'd0;
	localparam cfg_idx_t CFG_TILE_SHAPE = 2'd1;
	localparam cfg_idx_t CFG_MIRROR     = 2'd2;

	localparam cs_t CELL_SIZE_RST = 16'd256;

	// Geometry constants: sqrt(3)/2, sqrt(3), corner slope, all in 1/256
	localparam logic [7:0]  TRI_H_MUL  = 8'd222;
	localparam logic [8:0]  HEX_W_MUL  = 9'd443;
	localparam logic [8:0]  TRI_SLOPE  = 9'd443;
	localparam logic [7:0]  HEX_SLOPE  = 8'd148;
	// 1/3 as 43691 / 2^17, exact for values below 2^17
	localparam logic [15:0] RECIP3     = 16'd43691;
	localparam int          RECIP3_SH  = 17;
	// Cell id masks of the two triangle orientations
	localparam logic [31:0] TRI_UP_ID   = 32'h5555_5555;
	localparam logic [31:0] TRI_DOWN_ID = 32'hAAAA_AAAA;

	// Derived tile geometry, all non-negative and below 2^17
	typedef struct packed {
		dim_t cs;
		dim_t half;
		dim_t tri_h;
		dim_t tri_h3;
		dim_t tri_h23;
		dim_t hex_w;
		dim_t hex_w2;
		dim_t hex_h;
	} geom_t;

	// Sideband carried through the row divider
	typedef struct packed {
		coord_t x;
		coord_t y;
	} side_a_t;

	// Sideband carried through the column divider
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   row_odd;
		dim_t   ry;
	} side_b_t;

endpackage

`default_nettype wire

@@ hw/rtl/ctm_if.sv @@
`default_nettype none

// Point channel
interface ctm_in_if;
	import ctm_pkg::*;
	logic   valid;
	logic   ready;
	coord_t x_coord;
	coord_t y_coord;
	modport source(output valid, x_coord, y_coord, input ready);
	modport sink(input valid, x_coord, y_coord, output ready);
endinterface

// Local coordinate channel
interface ctm_out_if;
	import ctm_pkg::*;
	logic   valid;
	logic   ready;
	coord_t local_x;
	coord_t local_y;
	modport source(output valid, local_x, local_y, input ready);
	modport sink(input valid, local_x, local_y, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ctm_geom.sv @@
`default_nettype none

module ctm_geom (
	input  wire                logic clk,
	input  wire ctm_pkg::cs_t       cell_size,
	input  wire ctm_pkg::shape_t    tile_shape,
	output ctm_pkg::geom_t     geo,
	output ctm_pkg::dim_t      hdiv,
	output ctm_pkg::dim_t      wdiv
);
	import ctm_pkg::*;

	logic [23:0] tri_prod;
	logic [24:0] hexw_prod;
	logic [17:0] hexh_prod;
	dim_t        tri_h_n, hex_w_n, hex_h_n;
	logic [33:0] h3_prod, h23_prod;
	dim_t        cs_q, tri_h_q, hex_w_q, hex_h_q;
	dim_t        tri_h3_q, tri_h23_q;

	// First level: row heights and hex width, raised to 1 when they vanish
	always_comb begin
		tri_prod  = {8'd0, cell_size} * {16'd0, TRI_H_MUL};
		hexw_prod = {9'd0, cell_size} * {16'd0, HEX_W_MUL};
		hexh_prod = {1'b0, cell_size, 1'b0} + {2'b00, cell_size};
		tri_h_n   = {1'b0, tri_prod[23:8]};
		hex_w_n   = hexw_prod[24:8];
		hex_h_n   = hexh_prod[17:1];
		if (tri_h_n == '0) tri_h_n = DIM_W'(1);
		if (hex_w_n == '0) hex_w_n = DIM_W'(1);
		if (hex_h_n == '0) hex_h_n = DIM_W'(1);
	end

	always_ff @(posedge clk) begin
		cs_q    <= {1'b0, cell_size};
		tri_h_q <= tri_h_n;
		hex_w_q <= hex_w_n;
		hex_h_q <= hex_h_n;
	end

	// Second level: thirds of the triangle row height
	always_comb begin
		h3_prod  = {17'd0, tri_h_q} * {18'd0, RECIP3};
		h23_prod = {16'd0, tri_h_q, 1'b0} * {18'd0, RECIP3};
	end

	always_ff @(posedge clk) begin
		tri_h3_q  <= h3_prod[RECIP3_SH +: DIM_W];
		tri_h23_q <= h23_prod[RECIP3_SH +: DIM_W];
	end

	always_comb begin
		geo.cs      = cs_q;
		geo.half    = cs_q >> 1;
		geo.tri_h   = tri_h_q;
		geo.tri_h3  = tri_h3_q;
		geo.tri_h23 = tri_h23_q;
		geo.hex_w   = hex_w_q;
		geo.hex_w2  = hex_w_q >> 1;
		geo.hex_h   = hex_h_q;
	end

	// Divisors of the row and column steps
	always_comb begin
		case (tile_shape)
			SHAPE_TRIANGLE: begin
				hdiv = tri_h_q;
				wdiv = cs_q;
			end
			SHAPE_HEXAGON: begin
				hdiv = hex_h_q;
				wdiv = hex_w_q;
			end
			default: begin
				hdiv = cs_q;
				wdiv = cs_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/ctm_floor_div.sv @@
`default_nettype none

// Pipelined floor division of a signed word by a positive divisor,
// one quotient bit per stage, between an entry and an exit register.
module ctm_floor_div #(
	parameter type SIDE_T = logic
) (
	input  wire            logic clk,
	input  wire            logic arst_n,
	input  wire            logic en,
	input  wire            logic in_vld,
	input  wire ctm_pkg::coord_t in_num,
	input  wire ctm_pkg::dim_t   in_den,
	input  wire SIDE_T           in_side,
	output logic                 out_vld,
	output ctm_pkg::coord_t      out_quo,
	output ctm_pkg::dim_t        out_rem,
	output SIDE_T                out_side
);
	import ctm_pkg::*;

	logic             vld_s  [0:MAG_W];
	logic [MAG_W-1:0] num_s  [0:MAG_W];
	dim_t             rem_s  [0:MAG_W];
	dim_t             den_s  [0:MAG_W];
	logic             neg_s  [0:MAG_W];
	SIDE_T            side_s [0:MAG_W];

	logic   post_vld_s;
	coord_t post_quo_s;
	dim_t   post_rem_s;
	SIDE_T  post_side_s;

	// Entry: fold a negative dividend to its one's complement magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0]  <= in_num[DATA_W-1] ? ~in_num[MAG_W-1:0] : in_num[MAG_W-1:0];
			neg_s[0]  <= in_num[DATA_W-1];
			rem_s[0]  <= '0;
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	// Restoring steps
	for (genvar k = 0; k < MAG_W; k++) begin : g_step
		logic [DIM_W:0] trial;
		logic [DIM_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[k], num_s[k][MAG_W-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
				num_s[k+1]  <= {num_s[k][MAG_W-2:0], ge};
				neg_s[k+1]  <= neg_s[k];
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// Exit: undo the fold, floor quotient and non-negative remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_vld_s <= 1'b0;
		end else if (en) begin
			post_vld_s <= vld_s[MAG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			post_quo_s  <= neg_s[MAG_W] ? {1'b1, ~num_s[MAG_W]} : {1'b0, num_s[MAG_W]};
			post_rem_s  <= neg_s[MAG_W] ? den_s[MAG_W] - rem_s[MAG_W] - DIM_W'(1)
			                            : rem_s[MAG_W];
			post_side_s <= side_s[MAG_W];
		end
	end

	assign out_vld  = post_vld_s;
	assign out_quo  = post_quo_s;
	assign out_rem  = post_rem_s;
	assign out_side = post_side_s;

endmodule

`default_nettype wire

@@ hw/rtl/ctm_post.sv @@
`default_nettype none

// Per-shape local coordinates from the in-cell offsets (rx, ry).
// Two stages: slope products, then tile choice and offsets.
module ctm_post (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  wire             logic en,
	input  wire ctm_pkg::shape_t  tile_shape,
	input  wire             logic mirror_enable,
	input  wire ctm_pkg::geom_t   geo,
	input  wire             logic in_vld,
	input  wire ctm_pkg::coord_t  x,
	input  wire ctm_pkg::coord_t  y,
	input  wire ctm_pkg::dim_t    rx,
	input  wire ctm_pkg::dim_t    ry,
	input  wire             logic col_odd,
	input  wire             logic row_odd,
	output logic                  out_vld,
	output ctm_pkg::coord_t       lx,
	output ctm_pkg::coord_t       ly,
	output logic                  negate
);
	import ctm_pkg::*;

	function automatic coord_t zx(dim_t v);
		return coord_t'({{(DATA_W-DIM_W){1'b0}}, v});
	endfunction

	// Stage 1 products
	logic signed [DIM_W:0] dxs;
	dim_t                  dx;
	dim_t                  w_rem;
	logic [25:0]           prod_t;
	logic [24:0]           prod_l, prod_r;

	always_comb begin
		dxs    = $signed({1'b0, rx}) - $signed({1'b0, geo.half});
		dx     = dxs[DIM_W] ? DIM_W'(-dxs) : dxs[DIM_W-1:0];
		w_rem  = geo.hex_w - rx;
		prod_t = {9'd0, dx} * {17'd0, TRI_SLOPE};
		prod_l = {8'd0, rx} * {17'd0, HEX_SLOPE};
		prod_r = {8'd0, w_rem} * {17'd0, HEX_SLOPE};
	end

	logic        vld_s1;
	coord_t      x_s1, y_s1;
	dim_t        rx_s1, ry_s1;
	logic        col_odd_s1, row_odd_s1;
	logic        lt_half_s1, lt_w2_s1;
	logic [17:0] slope_t_s1;
	dim_t        slope_l_s1, slope_r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1       <= x;
			y_s1       <= y;
			rx_s1      <= rx;
			ry_s1      <= ry;
			col_odd_s1 <= col_odd;
			row_odd_s1 <= row_odd;
			lt_half_s1 <= rx < geo.half;
			lt_w2_s1   <= rx < geo.hex_w2;
			slope_t_s1 <= prod_t[25:8];
			slope_l_s1 <= prod_l[24:8];
			slope_r_s1 <= prod_r[24:8];
		end
	end

	// Stage 2: pick the tile and form offsets
	logic   pass;
	logic   up, move, dc_m1, dc_p1, row_o2, col_o2, c_odd, sq_flip;
	coord_t lx_n, ly_n;
	logic   neg_n;
	dim_t   corner;

	always_comb begin
		pass    = (geo.cs == '0) || (tile_shape == SHAPE_NONE);
		up      = {1'b0, ry_s1} > slope_t_s1;
		corner  = lt_w2_s1 ? slope_l_s1 : slope_r_s1;
		move    = ({1'b0, ry_s1} + {1'b0, corner}) < {1'b0, geo.half};
		dc_m1   = move & lt_w2_s1 & ~row_odd_s1;
		dc_p1   = move & ~lt_w2_s1 & row_odd_s1;
		row_o2  = row_odd_s1 ^ move;
		col_o2  = col_odd_s1 ^ (dc_m1 | dc_p1);
		c_odd   = lt_half_s1 ? col_odd_s1 : ~col_odd_s1;
		sq_flip = mirror_enable & (col_odd_s1 ^ row_odd_s1);
		lx_n    = x_s1;
		ly_n    = y_s1;
		neg_n   = 1'b0;
		if (!pass) begin
			case (tile_shape)
				SHAPE_SQUARE: begin
					lx_n = sq_flip ? zx(geo.cs) - zx(rx_s1) - coord_t'(1) : zx(rx_s1);
					ly_n = sq_flip ? zx(geo.cs) - zx(ry_s1) - coord_t'(1) : zx(ry_s1);
				end
				SHAPE_TRIANGLE: begin
					if (up) begin
						lx_n  = zx(rx_s1) - zx(geo.half);
						ly_n  = zx(ry_s1) - zx(geo.tri_h23);
						neg_n = mirror_enable & (col_odd_s1 ^ row_odd_s1 ^ TRI_UP_ID[0]);
					end else begin
						lx_n  = lt_half_s1 ? -zx(rx_s1) : zx(geo.cs) - zx(rx_s1);
						ly_n  = zx(geo.tri_h3) - zx(ry_s1);
						neg_n = mirror_enable & (c_odd ^ row_odd_s1 ^ TRI_DOWN_ID[0]);
					end
				end
				SHAPE_HEXAGON: begin
					lx_n  = zx(rx_s1)
					      + (row_odd_s1 ? zx(geo.hex_w2) : '0)
					      + (dc_m1 ? zx(geo.hex_w) : '0)
					      - (dc_p1 ? zx(geo.hex_w) : '0)
					      - (row_o2 ? zx(geo.hex_w) : zx(geo.hex_w2));
					ly_n  = zx(ry_s1) + (move ? zx(geo.hex_h) : '0) - zx(geo.cs);
					neg_n = mirror_enable & (col_o2 ^ row_o2);
				end
				default: begin
					lx_n = x_s1;
					ly_n = y_s1;
				end
			endcase
		end
	end

	logic   vld_s2;
	coord_t lx_s2, ly_s2;
	logic   neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s2  <= lx_n;
			ly_s2  <= ly_n;
			neg_s2 <= neg_n;
		end
	end

	assign out_vld = vld_s2;
	assign lx      = lx_s2;
	assign ly      = ly_s2;
	assign negate  = neg_s2;

endmodule

`default_nettype wire

@@ hw/rtl/cartesian_tiling_map.sv @@
`default_nettype none

// Maps a point (Q24.8) to its local coordinates within a square, triangle or
// pointy-top hexagon tile of side cell_size, optionally mirrored in odd cells;
// a zero cell size or the identity shape passes the point through. One point
// is taken per clock unless a result waits at the output and holds the whole
// pipeline; each point passes through one input register, two 33-stage floor
// dividers in series (the row index, then the column index whose offset
// depends on row parity), two shape stages and the output register. Write
// registers only while no point is in flight; the block does not enforce it.
module cartesian_tiling_map #(
	parameter int COORD_WIDTH = 32
) (
	input  wire                   logic clk,
	input  wire                   logic arst_n,
	ctm_in_if.sink                      in_pt,
	ctm_out_if.source                   out_loc,
	input  wire                   logic cfg_we,
	input  wire ctm_pkg::cfg_idx_t      cfg_idx,
	input  wire logic [ctm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ctm_pkg::*;

	localparam int SH = DATA_W - COORD_WIDTH;

	function automatic coord_t sext_w(coord_t v);
		coord_t t;
		t = v << SH;
		return coord_t'($signed(t) >>> SH);
	endfunction

	// Configuration registers
	cs_t    cell_size_q;
	shape_t tile_shape_q;
	logic   mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= CELL_SIZE_RST;
			tile_shape_q <= SHAPE_SQUARE;
			mirror_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CELL_SIZE:  cell_size_q  <= cfg_wdata[CS_W-1:0];
				CFG_TILE_SHAPE: tile_shape_q <= cfg_wdata[1:0];
				CFG_MIRROR:     mirror_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	geom_t geo;
	dim_t  hdiv, wdiv;

	ctm_geom u_geom (
		.clk        (clk),
		.cell_size  (cell_size_q),
		.tile_shape (tile_shape_q),
		.geo        (geo),
		.hdiv       (hdiv),
		.wdiv       (wdiv)
	);

	// Global advance: everything moves unless a result is held at the output
	logic out_vld_q;
	logic adv;

	assign adv         = ~out_vld_q | out_loc.ready;
	assign in_pt.ready = adv;

	// Input register
	logic   vld_s0;
	coord_t x_s0, y_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s0 <= sext_w(in_pt.x_coord);
			y_s0 <= sext_w(in_pt.y_coord);
		end
	end

	// Row division
	side_a_t side_a_in, side_a_out;
	logic    a_vld;
	coord_t  a_quo;
	dim_t    a_rem;

	assign side_a_in.x = x_s0;
	assign side_a_in.y = y_s0;

	ctm_floor_div #(.SIDE_T(side_a_t)) u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s0),
		.in_num   (y_s0),
		.in_den   (hdiv),
		.in_side  (side_a_in),
		.out_vld  (a_vld),
		.out_quo  (a_quo),
		.out_rem  (a_rem),
		.out_side (side_a_out)
	);

	// Odd rows shift by half a cell in triangle and hexagon tilings
	dim_t    xoff;
	coord_t  col_num;
	side_b_t side_b_in, side_b_out;

	always_comb begin
		case (tile_shape_q)
			SHAPE_TRIANGLE: xoff = a_quo[0] ? geo.half : '0;
			SHAPE_HEXAGON:  xoff = a_quo[0] ? geo.hex_w2 : '0;
			default:        xoff = '0;
		endcase
		col_num           = side_a_out.x - coord_t'({{(DATA_W-DIM_W){1'b0}}, xoff});
		side_b_in.x       = side_a_out.x;
		side_b_in.y       = side_a_out.y;
		side_b_in.row_odd = a_quo[0];
		side_b_in.ry      = a_rem;
	end

	// Column division
	logic   b_vld;
	coord_t b_quo;
	dim_t   b_rem;

	ctm_floor_div #(.SIDE_T(side_b_t)) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (a_vld),
		.in_num   (col_num),
		.in_den   (wdiv),
		.in_side  (side_b_in),
		.out_vld  (b_vld),
		.out_quo  (b_quo),
		.out_rem  (b_rem),
		.out_side (side_b_out)
	);

	// Shape stages
	logic   p_vld, p_neg;
	coord_t p_lx, p_ly;

	ctm_post u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.tile_shape    (tile_shape_q),
		.mirror_enable (mirror_q),
		.geo           (geo),
		.in_vld        (b_vld),
		.x             (side_b_out.x),
		.y             (side_b_out.y),
		.rx            (b_rem),
		.ry            (side_b_out.ry),
		.col_odd       (b_quo[0]),
		.row_odd       (side_b_out.row_odd),
		.out_vld       (p_vld),
		.lx            (p_lx),
		.ly            (p_ly),
		.negate        (p_neg)
	);

	// Output register: mirror negation and wrap to the coordinate width
	coord_t local_x_q, local_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= p_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			local_x_q <= sext_w(p_neg ? -p_lx : p_lx);
			local_y_q <= sext_w(p_neg ? -p_ly : p_ly);
		end
	end

	assign out_loc.valid   = out_vld_q;
	assign out_loc.local_x = local_x_q;
	assign out_loc.local_y = local_y_q;

endmodule

`default_nettype wire
